### design/gb3_pkg.sv
package gb3_pkg;

   // configuration port
   localparam int CSR_IW = 1;
   localparam int CSR_DW = 16;

   typedef enum logic [CSR_IW-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } gb3_csr_type;

   localparam int RST_IMAGE_WIDTH  = 2048;
   localparam int RST_IMAGE_HEIGHT = 1080;

   // result kinds carried by one queue entry, in emission order
   localparam int F_LAG   = 0;   // interior row, one row late (blur or left copy)
   localparam int F_RIGHT = 1;   // right border copy of the lagged row
   localparam int F_NOW   = 2;   // first or last row, copied at once

   // queue between front and back
   localparam int QDEPTH = 8;
   localparam int QAW    = 3;
   localparam int QCW    = 4;

   typedef struct packed {
      logic [2:0]  flags;
      logic [15:0] lag_pix;
      logic [15:0] right_pix;
      logic [15:0] now_pix;
      logic [15:0] row;
      logic [10:0] col;
   } gb3_entry_type;

   typedef struct packed {
      logic [QCW-1:0] count;
      logic           empty;
   } gb3_qstat_type;

endpackage

### design/gaussian_blur_3x3_border_copy.sv
// 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1, over 16, rounded half up) on a raster-order pixel
// stream, with the outer border copied unchanged. Rows 0 and the last row come out as their
// pixels arrive; interior rows come out one row late, so every result carries its row and
// column, and run_last marks the final result caused by one input pixel. A pixel is taken
// every cycle as long as results drain at one per cycle and the eight-entry result queue has
// room; the first result of a pixel is ready once it has passed the line buffer read, the
// window stage and the result queue. The extra result at the right edge of an interior row is
// absorbed by the queue, since the next pixel, at column 0, causes none unless in the last
// row. In the last row a pixel past column 0 causes two results, three at the right edge, so
// once the queue has filled the input is held back to the rate at which those results drain.
// Any configuration write restarts the frame at row 0, column 0; line buffers need no clearing
// after reset, as only pixels of the current frame are read.
module gaussian_blur_3x3_border_copy #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic [gb3_pkg::CSR_IW-1:0] csr_index,
   input  logic [gb3_pkg::CSR_DW-1:0] csr_wdata,
   input  logic                       req_push,
   input  logic [PIXEL_BITS-1:0]      req_pixel_in,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [15:0]                rsp_pixel_out,
   output logic [15:0]                rsp_out_row,
   output logic [10:0]                rsp_out_col,
   output logic                       rsp_run_last
);

   logic                   q_push;
   logic                   q_pop;
   gb3_pkg::gb3_entry_type q_entry;
   gb3_pkg::gb3_entry_type q_head;
   gb3_pkg::gb3_qstat_type q_stat;

   gb3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_pixel_in (req_pixel_in),
      .req_full     (req_full),
      .q_stat       (q_stat),
      .q_push       (q_push),
      .q_entry      (q_entry)
   );

   gb3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   gb3_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_run_last  (rsp_run_last)
   );

   // in-flight accounting must keep the queue from ever being pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_stat.count != gb3_pkg::QCW'(gb3_pkg::QDEPTH)))
      else $error("result queue pushed while full");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not idle after reset");

   // a beat that is not the last of its pixel leaves the entry in place
   a_hold_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_run_last) |=> !rsp_empty)
      else $error("entry dropped before its last result");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (rsp_pop && !rsp_empty && rsp_run_last))
      else $error("queue popped on a beat that was not last");

endmodule

### design/gb3_front.sv
module gb3_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [gb3_pkg::CSR_IW-1:0]    csr_index,
   input  logic [gb3_pkg::CSR_DW-1:0]    csr_wdata,
   input  logic                          req_push,
   input  logic [PIXEL_BITS-1:0]         req_pixel_in,
   output logic                          req_full,
   input  gb3_pkg::gb3_qstat_type        q_stat,
   output logic                          q_push,
   output gb3_pkg::gb3_entry_type        q_entry
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PB = PIXEL_BITS;
   localparam int SW = PIXEL_BITS + 4;
   localparam int OW = gb3_pkg::QCW + 1;
   localparam logic [AW-1:0] RST_WLAST = AW'(((MAX_WIDTH < gb3_pkg::RST_IMAGE_WIDTH) ?
                                              MAX_WIDTH : gb3_pkg::RST_IMAGE_WIDTH) - 1);
   localparam logic [15:0] RST_HLAST = 16'(gb3_pkg::RST_IMAGE_HEIGHT - 1);

   function automatic logic [15:0] to16(input logic [PB-1:0] v);
      logic [PB+15:0] x;
      x = {16'd0, v};
      return x[15:0];
   endfunction

   logic            accept;
   logic [OW-1:0]   occupancy;
   logic [11:0]     wval;
   logic [15:0]     hval;

   logic [AW-1:0]   wlast_ff, wlast_in;
   logic [15:0]     hlast_ff, hlast_in;
   logic [AW-1:0]   col_ff, col_in;
   logic [15:0]     row_ff, row_in;

   logic [2:0]      flags;
   logic [AW+10:0]  col_wide;

   // stage 1: line buffer read returns
   logic            s1_valid_ff;
   logic [AW-1:0]   s1_addr_ff;
   logic [PB-1:0]   s1_pix_ff;
   logic [15:0]     s1_row_ff;
   logic [10:0]     s1_col_ff;
   logic [2:0]      s1_flags_ff;
   logic            s1_c1_ff;
   logic            s1_fwd_ff;
   logic [2*PB-1:0] s1_fwd_data_ff;
   logic [2*PB-1:0] rdata_ff;
   logic [2*PB-1:0] s1_line;
   logic [PB-1:0]   s1_two;
   logic [PB-1:0]   s1_above;

   // stage 2: window holds this item's neighbourhood
   logic            s2_valid_ff;
   logic [15:0]     s2_pix_ff;
   logic [15:0]     s2_row_ff;
   logic [10:0]     s2_col_ff;
   logic [2:0]      s2_flags_ff;
   logic            s2_c1_ff;

   logic [PB-1:0]   win_ff [9];
   logic [SW-1:0]   blur_sum;
   logic [PB-1:0]   blur_pix;

   logic [2*PB-1:0] line_mem [MAX_WIDTH];

   // count items still in flight so the queue never overflows
   assign occupancy = {1'b0, q_stat.count} + OW'(s1_valid_ff) + OW'(s2_valid_ff);
   assign req_full  = occupancy >= OW'(gb3_pkg::QDEPTH);
   assign accept    = req_push && !req_full;

   assign wval = csr_wdata[11:0];
   assign hval = csr_wdata[15:0];

   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (csr_wen) begin
         col_in = '0;
         row_in = '0;
         case (csr_index)
            gb3_pkg::CSR_IMAGE_WIDTH: begin
               if (wval == 12'd0) begin
                  wlast_in = '0;
               end else if (int'(wval) > MAX_WIDTH) begin
                  wlast_in = AW'(MAX_WIDTH - 1);
               end else begin
                  wlast_in = AW'(wval - 12'd1);
               end
            end
            gb3_pkg::CSR_IMAGE_HEIGHT: begin
               hlast_in = (hval == 16'd0) ? 16'd0 : hval - 16'd1;
            end
            default: ;
         endcase
      end else if (accept) begin
         if (col_ff == wlast_ff) begin
            col_in = '0;
            row_in = (row_ff == hlast_ff) ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_comb begin
      flags                  = '0;
      flags[gb3_pkg::F_LAG]   = (|row_ff[15:1]) && (col_ff != '0);
      flags[gb3_pkg::F_RIGHT] = (|row_ff[15:1]) && (col_ff == wlast_ff);
      flags[gb3_pkg::F_NOW]   = (row_ff == 16'd0) || (row_ff == hlast_ff);
   end

   assign col_wide = {11'd0, col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff    <= RST_WLAST;
         hlast_ff    <= RST_HLAST;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         wlast_ff    <= wlast_in;
         hlast_ff    <= hlast_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // a write landing on the address read at the same edge is missed: forward it
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff     <= col_ff;
         s1_pix_ff      <= req_pixel_in;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_wide[10:0];
         s1_flags_ff    <= flags;
         s1_c1_ff       <= col_ff == AW'(1);
         s1_fwd_ff      <= s1_valid_ff && (s1_addr_ff == col_ff);
         s1_fwd_data_ff <= {s1_above, s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff <= line_mem[col_ff];
      end
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= {s1_above, s1_pix_ff};
      end
   end

   assign s1_line  = s1_fwd_ff ? s1_fwd_data_ff : rdata_ff;
   assign s1_two   = s1_line[2*PB-1:PB];
   assign s1_above = s1_line[PB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i*3]   <= win_ff[i*3+1];
            win_ff[i*3+1] <= win_ff[i*3+2];
         end
         win_ff[2] <= s1_two;
         win_ff[5] <= s1_above;
         win_ff[8] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_pix_ff   <= to16(s1_pix_ff);
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_flags_ff <= s1_flags_ff;
         s2_c1_ff    <= s1_c1_ff;
      end
   end

   // kernel 1-2-1 / 2-4-2 / 1-2-1, round half up, divide by 16
   assign blur_sum = SW'(win_ff[0]) + (SW'(win_ff[1]) << 1) + SW'(win_ff[2])
                   + (SW'(win_ff[3]) << 1) + (SW'(win_ff[4]) << 2) + (SW'(win_ff[5]) << 1)
                   + SW'(win_ff[6]) + (SW'(win_ff[7]) << 1) + SW'(win_ff[8]) + SW'(8);
   assign blur_pix = blur_sum[SW-1:4];

   assign q_push = s2_valid_ff && (|s2_flags_ff);

   always_comb begin
      q_entry.flags     = s2_flags_ff;
      q_entry.lag_pix   = s2_c1_ff ? to16(win_ff[4]) : to16(blur_pix);
      q_entry.right_pix = to16(win_ff[5]);
      q_entry.now_pix   = s2_pix_ff;
      q_entry.row       = s2_row_ff;
      q_entry.col       = s2_col_ff;
   end

endmodule

### design/gb3_queue.sv
module gb3_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gb3_pkg::gb3_entry_type push_entry,
   input  logic                   pop,
   output gb3_pkg::gb3_entry_type head,
   output gb3_pkg::gb3_qstat_type stat
);

   gb3_pkg::gb3_entry_type      slot_ff [gb3_pkg::QDEPTH];
   logic [gb3_pkg::QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [gb3_pkg::QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [gb3_pkg::QCW-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + gb3_pkg::QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + gb3_pkg::QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + gb3_pkg::QCW'(push) - gb3_pkg::QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head       = slot_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.empty = count_ff == '0;

endmodule

### design/gb3_back.sv
module gb3_back (
   input  logic                   clock,
   input  logic                   reset,
   input  gb3_pkg::gb3_entry_type head,
   input  gb3_pkg::gb3_qstat_type q_stat,
   output logic                   q_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic [15:0]            rsp_pixel_out,
   output logic [15:0]            rsp_out_row,
   output logic [10:0]            rsp_out_col,
   output logic                   rsp_run_last
);

   logic [2:0] done_ff, done_in;
   logic [2:0] remaining;
   logic [2:0] sel;
   logic       beat;

   assign remaining = head.flags & ~done_ff;
   assign rsp_empty = q_stat.empty;
   assign beat      = rsp_pop && !q_stat.empty;

   // emit the entry's results in raster order: lagged, right copy, current row
   always_comb begin
      sel           = '0;
      rsp_pixel_out = head.now_pix;
      rsp_out_row   = head.row;
      rsp_out_col   = head.col;
      if (remaining[gb3_pkg::F_LAG]) begin
         sel[gb3_pkg::F_LAG] = 1'b1;
         rsp_pixel_out       = head.lag_pix;
         rsp_out_row         = head.row - 16'd1;
         rsp_out_col         = head.col - 11'd1;
      end else if (remaining[gb3_pkg::F_RIGHT]) begin
         sel[gb3_pkg::F_RIGHT] = 1'b1;
         rsp_pixel_out         = head.right_pix;
         rsp_out_row           = head.row - 16'd1;
      end else begin
         sel[gb3_pkg::F_NOW] = 1'b1;
      end
   end

   assign rsp_run_last = (remaining & ~sel) == 3'd0;
   assign q_pop        = beat && rsp_run_last;

   always_comb begin
      done_in = done_ff;
      if (beat) begin
         done_in = rsp_run_last ? 3'd0 : (done_ff | sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

endmodule

### tb/gaussian_blur_3x3_border_copy_tb.sv
module gaussian_blur_3x3_border_copy_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_MAX    = 2048;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 210;

   typedef struct {
      logic [15:0] pixel;
      logic [15:0] row;
      logic [10:0] col;
      logic        last;
   } blur_pixel_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wen = 1'b0;
   logic [gb3_pkg::CSR_IW-1:0]  csr_index = '0;
   logic [gb3_pkg::CSR_DW-1:0]  csr_wdata = '0;
   logic                        req_push = 1'b0;
   logic [15:0]                 req_pixel_in = '0;
   logic                        req_full;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [15:0]                 rsp_pixel_out;
   logic [15:0]                 rsp_out_row;
   logic [10:0]                 rsp_out_col;
   logic                        rsp_run_last;

   // filter state mirrored by the testbench
   logic [15:0]  line_prev [LINE_MAX];
   logic [15:0]  line_prev2 [LINE_MAX];
   logic [15:0]  win [9];
   int unsigned  pos_row;
   int unsigned  pos_col;
   logic [11:0]  cfg_width;
   logic [15:0]  cfg_height;

   blur_pixel_type expected_pixels [$];

   bit           calm = 1'b0;
   int           hold_len = 0;
   int           hold_req_id = 0;
   int           hold_seen_id = 0;
   int           hold_left = 0;
   int           cycles = 0;
   int           mismatches = 0;
   int           results_checked = 0;
   int           pixels_sent = 0;
   int           frame_settings = 0;

   gaussian_blur_3x3_border_copy u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_pixel_in  (req_pixel_in),
      .req_full      (req_full),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_run_last  (rsp_run_last)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_pixels.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: random idling, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_seen_id != hold_req_id) begin
         hold_seen_id <= hold_req_id;
         hold_left <= hold_len;
         rsp_pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= calm || ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin : check_results
      blur_pixel_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected beat: pixel_out %h row %0d col %0d", rsp_pixel_out,
                   rsp_out_row, rsp_out_col);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (rsp_pixel_out !== want.pixel) begin
               $error("pixel_out: expected %h, got %h", want.pixel, rsp_pixel_out);
               mismatches++;
            end
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
               mismatches++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_out_col);
               mismatches++;
            end
            if (rsp_run_last !== want.last) begin
               $error("run_last: expected %b, got %b", want.last, rsp_run_last);
               mismatches++;
            end
         end
      end
   end

   function automatic int unsigned frame_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > LINE_MAX) return LINE_MAX;
      return cfg_width;
   endfunction

   function automatic int unsigned frame_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic logic [15:0] kernel_sum();
      int unsigned sum;
      sum = win[0] + 2 * win[1] + win[2]
          + 2 * win[3] + 4 * win[4] + 2 * win[5]
          + win[6] + 2 * win[7] + win[8];
      return 16'((sum + 8) >> 4);
   endfunction

   function automatic blur_pixel_type make_result(logic [15:0] pix, int unsigned row,
                                                  int unsigned col);
      blur_pixel_type res;
      res.pixel = pix;
      res.row = 16'(row);
      res.col = 11'(col);
      res.last = 1'b0;
      return res;
   endfunction

   // advance the window by one pixel and queue the results it releases
   function automatic void predict_filter(logic [15:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      blur_pixel_type fresh [$];
      w = frame_width();
      h = frame_height();
      r = (pos_row >= h) ? 0 : pos_row;
      c = (pos_col >= w) ? 0 : pos_col;
      for (int i = 0; i < 3; i++) begin
         win[i*3]   = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = line_prev2[c];
      win[5] = line_prev[c];
      win[8] = pix;
      line_prev2[c] = line_prev[c];
      line_prev[c] = pix;
      if (r == 0) begin
         fresh.push_back(make_result(pix, r, c));
      end else begin
         if (r >= 2) begin
            if (c >= 1)
               fresh.push_back(make_result((c == 1) ? win[4] : kernel_sum(), r - 1, c - 1));
            if (c == w - 1)
               fresh.push_back(make_result(win[5], r - 1, c));
         end
         if (r == h - 1)
            fresh.push_back(make_result(pix, r, c));
      end
      if (fresh.size() != 0)
         fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i])
         expected_pixels.push_back(fresh[i]);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h)
            r = 0;
      end
      pos_row = r;
      pos_col = c;
   endfunction

   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_pixel(input logic [15:0] pix);
      if (!calm && $urandom_range(99) < 12) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_full);
      predict_filter(pix);
      pixels_sent++;
   endtask

   task automatic push_random(input int count);
      repeat (count) push_pixel(rand_pixel());
   endtask

   // drop push, drain, then allow for a pixel that releases no beat
   task automatic settle();
      req_push <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input gb3_pkg::gb3_csr_type idx, input logic [15:0] data);
      req_push <= 1'b0;
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == gb3_pkg::CSR_IMAGE_WIDTH)
         cfg_width = data[11:0];
      else
         cfg_height = data;
      pos_row = 0;
      pos_col = 0;
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper bits of the width write carry random junk
   task automatic set_frame(input int unsigned w, input int unsigned h);
      write_csr(gb3_pkg::CSR_IMAGE_WIDTH, {4'($urandom_range(15)), 12'(w)});
      write_csr(gb3_pkg::CSR_IMAGE_HEIGHT, 16'(h));
      frame_settings++;
   endtask

   task automatic test_reset_values();
      push_pixel(16'h0000);
      push_pixel(16'hFFFF);
      push_pixel(16'h5555);
      push_pixel(16'hAAAA);
      settle();
   endtask

   task automatic test_small_frames();
      logic [15:0] spot [9];
      spot = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0};
      set_frame(3, 3);
      foreach (spot[i])
         push_pixel(spot[i]);
      settle();
      set_frame(4, 3);
      repeat (12) push_pixel(16'hFFFF);
      settle();
   endtask

   task automatic test_degenerate_sizes();
      set_frame(0, 0);
      push_random(3);
      settle();
      set_frame(1, 3);
      push_random(3);
      settle();
      set_frame(2, 2);
      push_random(4);
      settle();
   endtask

   task automatic test_restart_mid_frame();
      set_frame(4, 4);
      push_random(6);
      settle();
      write_csr(gb3_pkg::CSR_IMAGE_WIDTH, 16'd5);
      write_csr(gb3_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      push_random(15);
      settle();
   endtask

   task automatic test_extreme_sizes();
      set_frame(2048, 3);
      push_random(40);
      settle();
      set_frame(4095, 1);
      push_random(40);
      settle();
      set_frame(7, 65535);
      push_random(20);
      settle();
   endtask

   task automatic test_backpressure();
      set_frame(6, 5);
      calm = 1'b1;
      hold_len = 200;
      hold_req_id++;
      push_random(60);
      calm = 1'b0;
      settle();
   endtask

   task automatic test_random_frames();
      int sent;
      int unsigned w;
      int unsigned h;
      int unsigned area;
      int count;
      sent = 0;
      calm = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         if (sent > 120)
            calm = 1'b0;
         case ($urandom_range(9))
            0: w = 0;
            1: w = $urandom_range(13, 40);
            default: w = $urandom_range(1, 8);
         endcase
         h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 7);
         set_frame(w, h);
         area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
         // mostly whole frames, now and then a cut-off one
         if ($urandom_range(4) == 0)
            count = $urandom_range(1, area);
         else
            count = area * $urandom_range(1, 2);
         if (count > RANDOM_ITEMS - sent)
            count = RANDOM_ITEMS - sent;
         push_random(count);
         sent += count;
         settle();
      end
      calm = 1'b0;
   endtask

   initial begin
      foreach (line_prev[i]) begin
         line_prev[i] = '0;
         line_prev2[i] = '0;
      end
      foreach (win[i])
         win[i] = '0;
      pos_row = 0;
      pos_col = 0;
      cfg_width = 12'(gb3_pkg::RST_IMAGE_WIDTH);
      cfg_height = 16'(gb3_pkg::RST_IMAGE_HEIGHT);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_small_frames();
      test_degenerate_sizes();
      test_restart_mid_frame();
      test_extreme_sizes();
      test_backpressure();
      test_random_frames();
      settle();

      $display("Streamed %0d pixels through %0d frame geometries, 1x1 up to 2048 wide,",
               pixels_sent, frame_settings);
      $display("with mid-frame restarts and a long output stall; %0d beats checked.",
               results_checked);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### gaussian_blur_3x3_border_copy.f
design/gb3_pkg.sv
design/gb3_front.sv
design/gb3_queue.sv
design/gb3_back.sv
design/gaussian_blur_3x3_border_copy.sv
tb/gaussian_blur_3x3_border_copy_tb.sv
